// ----- rtl/hdset_pkg.sv -----
// ----------------------------------------------------------------------------
// hdset_pkg
// Shared constants, types and the start-slot hash of the dedup hash set.
// ----------------------------------------------------------------------------
package hdset_pkg;

  localparam int unsigned TableIndexBits = 12;
  localparam int unsigned MaxProbes      = 8;

  localparam int unsigned SlotCount = 1 << TableIndexBits;
  localparam int unsigned KeyW      = 31;
  localparam int unsigned PcntW     = (MaxProbes > 1) ? $clog2(MaxProbes) : 1;
  localparam int unsigned SumW      =
      ((TableIndexBits > PcntW) ? TableIndexBits : PcntW) + 1;

  localparam int unsigned HashMul = 99991;
  localparam int unsigned HashAdd = 101;

  typedef logic [TableIndexBits-1:0] idx_t;
  typedef logic [KeyW-1:0]           key_t;
  typedef logic [PcntW-1:0]          pcnt_t;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StHit      = 2'd1,
    StDropped  = 2'd2,
    StCleared  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SSweep,
    SIdle,
    SHash,
    SRead,
    SCmp,
    SResp
  } state_e;

  // Low index bits of key*HashMul + rotl32(key,2) + HashAdd; bit 31 of key is zero.
  function automatic idx_t start_slot(key_t key);
    idx_t kl;
    idx_t mul;
    idx_t rot;
    kl  = key[TableIndexBits-1:0];
    mul = idx_t'(kl * idx_t'(HashMul));
    rot = {key[TableIndexBits-3:0], 1'b0, key[KeyW-1]};
    return idx_t'(mul + rot + idx_t'(HashAdd));
  endfunction

endpackage

// ----- rtl/hdset_req_if.sv -----
// ----------------------------------------------------------------------------
// hdset_req_if
// Request channel: check-and-set or clear words with valid/ready.
// ----------------------------------------------------------------------------
interface hdset_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [hdset_pkg::KeyW-1:0] item_id;

  modport source (output valid, output req_type, output item_id, input ready);
  modport sink   (input valid, input req_type, input item_id, output ready);
endinterface

// ----- rtl/hdset_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hdset_rsp_if
// Response channel: one result word per request with valid/ready.
// ----------------------------------------------------------------------------
interface hdset_rsp_if;
  logic       valid;
  logic       ready;
  logic       already_seen;
  logic [1:0] status;

  modport source (output valid, output already_seen, output status, input ready);
  modport sink   (input valid, input already_seen, input status, output ready);
endinterface

// ----- rtl/hash_dedup_set.sv -----
// ----------------------------------------------------------------------------
// hash_dedup_set
// Deduplication set of item IDs in two open-addressing hash blocks, probed
// by one shared read/compare step under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req_i    in   req_type, item_id
//  rsp_o    out  already_seen, status
//
//  Check: a hash step, then n probes (1 .. 2*MaxProbes), each a RAM read step
//  and a compare/write step, then a response step. An all-ones item_id skips
//  the hash and the probes. Clear: all SlotCount slots are swept, one slot
//  per cycle zeroed in the first block and, if used since the last sweep, in
//  the second. After reset the same sweep clears both blocks before
//  req_i.ready. A waiting response holds the sequencer in its response state.
// ----------------------------------------------------------------------------
module hash_dedup_set (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdset_req_if.sink   req_i,
  hdset_rsp_if.source rsp_o
);

  hdset_pkg::state_e  state_q, state_d;
  logic               sweep_rsp_q;
  hdset_pkg::idx_t    sweep_cnt_q;
  logic               second_used_q;
  logic               blk_q;
  hdset_pkg::pcnt_t   pcnt_q;
  logic               rsp_valid_q;

  hdset_pkg::key_t    key_q;
  hdset_pkg::idx_t    start_q;
  hdset_pkg::idx_t    slot_q;
  hdset_pkg::status_e result_q;
  logic               rsp_seen_q;
  hdset_pkg::status_e rsp_status_q;

  logic               accept;
  logic               id_full;
  logic               we_first;
  logic               we_second;
  hdset_pkg::idx_t    ram_addr;
  hdset_pkg::key_t    ram_wdata;
  hdset_pkg::key_t    rd_first;
  hdset_pkg::key_t    rd_second;
  hdset_pkg::key_t    rdata;
  logic               slot_empty;
  logic               slot_hit;
  logic               last_probe;
  logic               load_rsp;
  logic [hdset_pkg::SumW-1:0] slot_sum;

  assign accept     = req_i.valid && req_i.ready;
  assign id_full    = &req_i.item_id;
  assign rdata      = blk_q ? rd_second : rd_first;
  assign slot_empty = (rdata == '0);
  assign slot_hit   = (rdata == key_q);
  assign last_probe = (pcnt_q == hdset_pkg::pcnt_t'(hdset_pkg::MaxProbes - 1));
  assign slot_sum   = hdset_pkg::SumW'(slot_q) + hdset_pkg::SumW'(pcnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      hdset_pkg::SSweep: begin
        if (sweep_cnt_q == hdset_pkg::idx_t'(hdset_pkg::SlotCount - 1)) begin
          state_d = sweep_rsp_q ? hdset_pkg::SResp : hdset_pkg::SIdle;
        end
      end
      hdset_pkg::SIdle: begin
        if (accept) begin
          if (req_i.req_type) begin
            state_d = hdset_pkg::SSweep;
          end else if (id_full) begin
            state_d = hdset_pkg::SResp;
          end else begin
            state_d = hdset_pkg::SHash;
          end
        end
      end
      hdset_pkg::SHash: state_d = hdset_pkg::SRead;
      hdset_pkg::SRead: state_d = hdset_pkg::SCmp;
      hdset_pkg::SCmp: begin
        if (slot_empty || slot_hit || (last_probe && blk_q)) begin
          state_d = hdset_pkg::SResp;
        end else begin
          state_d = hdset_pkg::SRead;
        end
      end
      hdset_pkg::SResp: begin
        if (load_rsp) begin
          state_d = hdset_pkg::SIdle;
        end
      end
      default: state_d = hdset_pkg::SSweep;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    we_first    = 1'b0;
    we_second   = 1'b0;
    ram_addr    = slot_q;
    ram_wdata   = key_q;
    load_rsp    = 1'b0;
    case (state_q)
      hdset_pkg::SSweep: begin
        ram_addr  = sweep_cnt_q;
        ram_wdata = '0;
        we_first  = 1'b1;
        we_second = !sweep_rsp_q || second_used_q;
      end
      hdset_pkg::SIdle: req_i.ready = 1'b1;
      hdset_pkg::SCmp: begin
        we_first  = slot_empty && !blk_q;
        we_second = slot_empty && blk_q;
      end
      hdset_pkg::SResp: load_rsp = !rsp_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= hdset_pkg::SSweep;
      sweep_rsp_q   <= 1'b0;
      sweep_cnt_q   <= '0;
      second_used_q <= 1'b0;
      blk_q         <= 1'b0;
      pcnt_q        <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        hdset_pkg::SSweep: begin
          sweep_cnt_q <= sweep_cnt_q + 1'b1;
          if (sweep_cnt_q == hdset_pkg::idx_t'(hdset_pkg::SlotCount - 1)) begin
            second_used_q <= 1'b0;
          end
        end
        hdset_pkg::SIdle: begin
          if (accept) begin
            sweep_rsp_q <= 1'b1;
            sweep_cnt_q <= '0;
            blk_q       <= 1'b0;
            pcnt_q      <= '0;
          end
        end
        hdset_pkg::SCmp: begin
          if (!slot_empty && !slot_hit) begin
            if (last_probe) begin
              if (!blk_q) begin
                blk_q         <= 1'b1;
                second_used_q <= 1'b1;
                pcnt_q        <= '0;
              end
            end else begin
              pcnt_q <= pcnt_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      hdset_pkg::SIdle: begin
        if (accept) begin
          key_q <= req_i.item_id + 1'b1;
          if (req_i.req_type) begin
            result_q <= hdset_pkg::StCleared;
          end else begin
            result_q <= hdset_pkg::StDropped;
          end
        end
      end
      hdset_pkg::SHash: begin
        start_q <= hdset_pkg::start_slot(key_q);
        slot_q  <= hdset_pkg::start_slot(key_q);
      end
      hdset_pkg::SCmp: begin
        if (slot_empty) begin
          result_q <= hdset_pkg::StInserted;
        end else if (slot_hit) begin
          result_q <= hdset_pkg::StHit;
        end else if (last_probe) begin
          slot_q <= start_q;
        end else begin
          slot_q <= slot_sum[hdset_pkg::TableIndexBits-1:0];
        end
      end
      default: ;
    endcase
    if (load_rsp) begin
      rsp_seen_q   <= (result_q == hdset_pkg::StHit);
      rsp_status_q <= result_q;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.already_seen = rsp_seen_q;
  assign rsp_o.status       = rsp_status_q;

  hdset_ram #(
    .WIDTH (hdset_pkg::KeyW),
    .DEPTH (hdset_pkg::SlotCount)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we_first),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_first)
  );

  hdset_ram #(
    .WIDTH (hdset_pkg::KeyW),
    .DEPTH (hdset_pkg::SlotCount)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we_second),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rd_second)
  );

endmodule

// ----- rtl/hdset_ram.sv -----
// ----------------------------------------------------------------------------
// hdset_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hdset_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- tb/sv/hdset_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdset_tb_pkg
// Request codes and identifier constants shared by the dedup set testbench.
// ----------------------------------------------------------------------------
package hdset_tb_pkg;

  typedef enum logic {
    ReqCheck = 1'b0,
    ReqClear = 1'b1
  } req_e;

  localparam logic [hdset_pkg::KeyW-1:0] IdAllOnes = '1;

endpackage

// ----- tb/sv/hdset_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hdset_checker
// Passive checker for the dedup hash set: mirrors both hash blocks, predicts
// the response word of every accepted request and compares it field by field
// with the responses leaving the block, in order.
// ----------------------------------------------------------------------------
module hdset_checker
  import hdset_pkg::*;
  import hdset_tb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  hdset_req_if req_i,
  hdset_rsp_if rsp_i,
  input  logic end_check_i,
  output int   errors_o,
  output int   due_o,
  output int   n_req_o,
  output int   n_insert_o,
  output int   n_hit_o,
  output int   n_drop_o,
  output int   n_clear_o,
  output int   n_spill_o
);

  typedef struct packed {
    logic    seen;
    status_e status;
  } dedup_word_t;

  key_t        slot_mem [2][SlotCount];
  logic        spill_used;
  dedup_word_t rsp_due [$];
  dedup_word_t want;
  logic        end_done = 1'b0;

  int errors = 0, due_count = 0, n_req = 0, n_insert = 0, n_hit = 0, n_drop = 0,
      n_clear = 0, n_spill = 0;

  assign errors_o   = errors;
  assign due_o      = due_count;
  assign n_req_o    = n_req;
  assign n_insert_o = n_insert;
  assign n_hit_o    = n_hit;
  assign n_drop_o   = n_drop;
  assign n_clear_o  = n_clear;
  assign n_spill_o  = n_spill;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic void wipe_block(input int blk);
    for (int i = 0; i < SlotCount; i++) slot_mem[blk][i] = '0;
  endfunction

  function automatic idx_t hash_slot(input logic [31:0] key);
    logic [31:0] mul;
    logic [31:0] rot;
    logic [31:0] sum;
    mul = key * 32'd99991;
    rot = {key[29:0], key[31:30]};
    sum = mul + rot + 32'd101;
    return sum[TableIndexBits-1:0];
  endfunction

  function automatic status_e probe_block(input int blk, input key_t key);
    idx_t slot;
    slot = hash_slot({1'b0, key});
    for (int p = 0; p < MaxProbes; p++) begin
      if (slot_mem[blk][slot] == '0) begin
        slot_mem[blk][slot] = key;
        return StInserted;
      end
      if (slot_mem[blk][slot] == key) return StHit;
      slot = slot + idx_t'(p);
    end
    return StDropped;
  endfunction

  function automatic dedup_word_t dedup_lookup(input logic kind, input key_t id);
    dedup_word_t w;
    status_e     st;
    key_t        key;
    w.seen = 1'b0;
    if (kind == ReqClear) begin
      wipe_block(0);
      if (spill_used) begin
        wipe_block(1);
        spill_used = 1'b0;
      end
      w.status = StCleared;
      return w;
    end
    if (id == IdAllOnes) begin
      w.status = StDropped;
      return w;
    end
    key = id + key_t'(1);
    st  = probe_block(0, key);
    if (st == StDropped) begin
      spill_used = 1'b1;
      n_spill++;
      st = probe_block(1, key);
    end
    w.seen   = (st == StHit);
    w.status = st;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_block(0);
      wipe_block(1);
      spill_used = 1'b0;
      rsp_due.delete();
      due_count = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (rsp_due.size() == 0) begin
          report_mismatch($sformatf("response word seen=%b status=%0d with none pending",
                                    rsp_i.already_seen, rsp_i.status));
        end else begin
          want = rsp_due.pop_front();
          if (rsp_i.already_seen !== want.seen)
            report_mismatch($sformatf("already_seen %b, predicted %b",
                                      rsp_i.already_seen, want.seen));
          if (rsp_i.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d (%s)",
                                      rsp_i.status, want.status, want.status.name()));
        end
      end
      if (req_i.valid && req_i.ready) begin
        want = dedup_lookup(req_i.req_type, req_i.item_id);
        rsp_due.push_back(want);
        n_req++;
        case (want.status)
          StInserted: n_insert++;
          StHit:      n_hit++;
          StDropped:  n_drop++;
          default:    n_clear++;
        endcase
      end
      due_count = rsp_due.size();
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (rsp_due.size() != 0)
          report_mismatch($sformatf("%0d response words never arrived", rsp_due.size()));
      end
    end
  end

endmodule

// ----- tb/sv/tb_hash_dedup_set.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_dedup_set
// Stimulus and verdict for the dedup hash set: directed corner requests, then
// random check and clear words biased toward colliding keys so both blocks
// fill and spill, under three idling mixes and one long response stall.
// ----------------------------------------------------------------------------
module tb_hash_dedup_set;
  import hdset_pkg::*;
  import hdset_tb_pkg::*;

  localparam int PhaseItems  = 417;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 64;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic end_check;

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_asked;
  int hold_taken;
  int hold_left;

  int errors, due, n_req, n_insert, n_hit, n_drop, n_clear, n_spill;

  hdset_req_if req_if ();
  hdset_rsp_if rsp_if ();

  hash_dedup_set dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  hdset_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .end_check_i (end_check),
    .errors_o    (errors),
    .due_o       (due),
    .n_req_o     (n_req),
    .n_insert_o  (n_insert),
    .n_hit_o     (n_hit),
    .n_drop_o    (n_drop),
    .n_clear_o   (n_clear),
    .n_spill_o   (n_spill)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hold off the response side for a stretch whenever asked, else idle at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_taken   <= hold_asked;
      hold_left    <= 0;
    end else if (hold_taken != hold_asked) begin
      hold_taken   <= hold_asked;
      hold_left    <= HoldCycles;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(input req_e kind, input key_t id);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.item_id  <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic send_random();
    int   pick;
    key_t id;
    pick = $urandom_range(999);
    if (pick < 10) begin
      send_word(ReqClear, key_t'($urandom));
    end else if (pick < 18) begin
      send_word(ReqCheck, IdAllOnes);
    end else if (pick < 300) begin
      send_word(ReqCheck, key_t'($urandom));
    end else begin
      // colliding keys: same low bits and bit 30 share a start slot
      id         = '0;
      id[30]     = 1'($urandom_range(1));
      id[29:12]  = 18'($urandom_range(19));
      case ($urandom_range(2))
        0:       id[11:0] = 12'h005;
        1:       id[11:0] = 12'h7a3;
        default: id[11:0] = 12'hc40;
      endcase
      send_word(ReqCheck, id);
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    end_check       <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.req_type <= ReqCheck;
    req_if.item_id  <= '0;
    tx_idle_pct     = 13;
    rx_idle_pct     <= 47;
    hold_asked      <= 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(ReqCheck, key_t'(0));
    send_word(ReqCheck, key_t'(0));
    send_word(ReqCheck, IdAllOnes - key_t'(1));
    send_word(ReqCheck, IdAllOnes - key_t'(1));
    send_word(ReqCheck, IdAllOnes);
    send_word(ReqClear, key_t'(0));
    send_word(ReqCheck, key_t'(0));
    // one start slot: fill the first block, spill into the second, then drop
    for (int k = 0; k < 16; k++) send_word(ReqCheck, key_t'(5 + k * 4096));
    send_word(ReqCheck, key_t'(5 + 9 * 4096));
    send_word(ReqClear, IdAllOnes);

    for (int i = 0; i < PhaseItems; i++) send_random();
    tx_idle_pct = 47;
    rx_idle_pct <= 13;
    for (int i = 0; i < PhaseItems; i++) send_random();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_asked  <= hold_asked + 1;
    for (int i = 0; i < PhaseItems; i++) send_random();
    req_if.valid <= 1'b0;

    while (due != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    end_check <= 1'b1;
    repeat (2) @(posedge clk_i);

    $display("covered %0d requests: %0d inserts, %0d hits, %0d drops, %0d clears",
             n_req, n_insert, n_hit, n_drop, n_clear);
    $display("second block probed by %0d checks; one %0d-cycle response stall",
             n_spill, HoldCycles);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("timeout with %0d response words pending", due);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
